// File: hdl/mitt_pkg.sv
// ----------------------------------------------------------------------------
// mitt_pkg
// Shared types, microcode store and lookup tables for the MIPS text unit.
// ----------------------------------------------------------------------------
package mitt_pkg;

	localparam int PC_W = 6;

	// micro-op codes
	localparam logic [2:0] OP_CHAR  = 3'd0;
	localparam logic [2:0] OP_REGA  = 3'd1;
	localparam logic [2:0] OP_REGB  = 3'd2;
	localparam logic [2:0] OP_WAIT  = 3'd3;
	localparam logic [2:0] OP_DIGIT = 3'd4;
	localparam logic [2:0] OP_UNK   = 3'd5;

	// register field select
	localparam logic [1:0] SEL_RS = 2'd0;
	localparam logic [1:0] SEL_RT = 2'd1;
	localparam logic [1:0] SEL_RD = 2'd2;

	// MIPS opcodes and function codes
	localparam logic [5:0] OPC_RTYPE = 6'd0;
	localparam logic [5:0] OPC_J     = 6'd2;
	localparam logic [5:0] OPC_BEQ   = 6'd4;
	localparam logic [5:0] OPC_LW    = 6'd35;
	localparam logic [5:0] OPC_SW    = 6'd43;
	localparam logic [5:0] FN_ADD    = 6'd32;
	localparam logic [5:0] FN_SUB    = 6'd34;
	localparam logic [5:0] FN_SLT    = 6'd42;

	// program entry points
	localparam logic [PC_W-1:0] PC_UNK = 6'd0;
	localparam logic [PC_W-1:0] PC_ADD = 6'd1;
	localparam logic [PC_W-1:0] PC_SUB = 6'd4;
	localparam logic [PC_W-1:0] PC_SLT = 6'd7;
	localparam logic [PC_W-1:0] PC_RT  = 6'd10;
	localparam logic [PC_W-1:0] PC_LW  = 6'd22;
	localparam logic [PC_W-1:0] PC_SW  = 6'd24;
	localparam logic [PC_W-1:0] PC_LS  = 6'd26;
	localparam logic [PC_W-1:0] PC_BEQ = 6'd38;
	localparam logic [PC_W-1:0] PC_J   = 6'd52;

	// converter: two binary bits per cycle
	localparam int BCD_DIGITS = 8;
	localparam int BIN_W      = 26;
	localparam int IMM_W      = 16;
	localparam logic [3:0] CNT_IMM = 4'd8;
	localparam logic [3:0] CNT_TGT = 4'd13;

	typedef struct packed {
		logic [2:0]      op;
		logic [6:0]      chr;
		logic [1:0]      rsel;
		logic            last;
		logic            jmp;
		logic [PC_W-1:0] tgt;
	} ucode_t;

	function automatic logic [6:0] asc(input logic [7:0] c);
		return c[6:0];
	endfunction

	function automatic ucode_t uc_c(input logic [7:0] c, input logic last);
		ucode_t w;
		w = '0;
		w.op = OP_CHAR;
		w.chr = c[6:0];
		w.last = last;
		return w;
	endfunction

	function automatic ucode_t uc_cj(input logic [7:0] c, input logic [PC_W-1:0] tgt);
		ucode_t w;
		w = uc_c(c, 1'b0);
		w.jmp = 1'b1;
		w.tgt = tgt;
		return w;
	endfunction

	function automatic ucode_t uc_o(input logic [2:0] op, input logic [1:0] rsel,
			input logic last);
		ucode_t w;
		w = '0;
		w.op = op;
		w.rsel = rsel;
		w.last = last;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			6'd0:  w = uc_o(OP_UNK, SEL_RS, 1'b1);
			// add / sub / slt mnemonics
			6'd1:  w = uc_c("a", 1'b0);
			6'd2:  w = uc_c("d", 1'b0);
			6'd3:  w = uc_cj("d", PC_RT);
			6'd4:  w = uc_c("s", 1'b0);
			6'd5:  w = uc_c("u", 1'b0);
			6'd6:  w = uc_cj("b", PC_RT);
			6'd7:  w = uc_c("s", 1'b0);
			6'd8:  w = uc_c("l", 1'b0);
			6'd9:  w = uc_c("t", 1'b0);
			// " rd,rs,rt"
			6'd10: w = uc_c(" ", 1'b0);
			6'd11: w = uc_c("$", 1'b0);
			6'd12: w = uc_o(OP_REGA, SEL_RD, 1'b0);
			6'd13: w = uc_o(OP_REGB, SEL_RD, 1'b0);
			6'd14: w = uc_c(",", 1'b0);
			6'd15: w = uc_c("$", 1'b0);
			6'd16: w = uc_o(OP_REGA, SEL_RS, 1'b0);
			6'd17: w = uc_o(OP_REGB, SEL_RS, 1'b0);
			6'd18: w = uc_c(",", 1'b0);
			6'd19: w = uc_c("$", 1'b0);
			6'd20: w = uc_o(OP_REGA, SEL_RT, 1'b1);
			6'd21: w = uc_o(OP_REGB, SEL_RT, 1'b1);
			// lw / sw
			6'd22: w = uc_c("l", 1'b0);
			6'd23: w = uc_cj("w", PC_LS);
			6'd24: w = uc_c("s", 1'b0);
			6'd25: w = uc_c("w", 1'b0);
			6'd26: w = uc_c(" ", 1'b0);
			6'd27: w = uc_c("$", 1'b0);
			6'd28: w = uc_o(OP_REGA, SEL_RT, 1'b0);
			6'd29: w = uc_o(OP_REGB, SEL_RT, 1'b0);
			6'd30: w = uc_c(",", 1'b0);
			6'd31: w = uc_o(OP_WAIT, SEL_RS, 1'b0);
			6'd32: w = uc_o(OP_DIGIT, SEL_RS, 1'b0);
			6'd33: w = uc_c("(", 1'b0);
			6'd34: w = uc_c("$", 1'b0);
			6'd35: w = uc_o(OP_REGA, SEL_RS, 1'b0);
			6'd36: w = uc_o(OP_REGB, SEL_RS, 1'b0);
			6'd37: w = uc_c(")", 1'b1);
			// beq
			6'd38: w = uc_c("b", 1'b0);
			6'd39: w = uc_c("e", 1'b0);
			6'd40: w = uc_c("q", 1'b0);
			6'd41: w = uc_c(" ", 1'b0);
			6'd42: w = uc_c("$", 1'b0);
			6'd43: w = uc_o(OP_REGA, SEL_RS, 1'b0);
			6'd44: w = uc_o(OP_REGB, SEL_RS, 1'b0);
			6'd45: w = uc_c(",", 1'b0);
			6'd46: w = uc_c("$", 1'b0);
			6'd47: w = uc_o(OP_REGA, SEL_RT, 1'b0);
			6'd48: w = uc_o(OP_REGB, SEL_RT, 1'b0);
			6'd49: w = uc_c(",", 1'b0);
			6'd50: w = uc_o(OP_WAIT, SEL_RS, 1'b0);
			6'd51: w = uc_o(OP_DIGIT, SEL_RS, 1'b1);
			// j
			6'd52: w = uc_c("j", 1'b0);
			6'd53: w = uc_c(" ", 1'b0);
			6'd54: w = uc_o(OP_WAIT, SEL_RS, 1'b0);
			6'd55: w = uc_o(OP_DIGIT, SEL_RS, 1'b1);
			default: w = uc_o(OP_UNK, SEL_RS, 1'b1);
		endcase
		return w;
	endfunction

	// second character of a register name
	function automatic logic [6:0] reg_char1(input logic [4:0] r);
		logic [6:0] c;
		case (r) inside
			5'd0:           c = asc("0");
			5'd1:           c = asc("a");
			5'd2, 5'd3:     c = asc("v");
			[5'd4:5'd7]:    c = asc("a");
			[5'd8:5'd15]:   c = asc("t");
			[5'd16:5'd23]:  c = asc("s");
			5'd24, 5'd25:   c = asc("t");
			5'd26, 5'd27:   c = asc("k");
			5'd28:          c = asc("g");
			5'd29:          c = asc("s");
			5'd30:          c = asc("f");
			default:        c = asc("r");
		endcase
		return c;
	endfunction

	// third character of a register name
	function automatic logic [6:0] reg_char2(input logic [4:0] r);
		logic [6:0] c;
		case (r) inside
			5'd0:                  c = asc(" ");
			5'd1:                  c = asc("t");
			5'd2, 5'd4, 5'd26:     c = asc("0");
			5'd3, 5'd5, 5'd27:     c = asc("1");
			5'd6:                  c = asc("2");
			5'd7:                  c = asc("3");
			[5'd8:5'd15]:          c = asc("0") + {4'd0, r[2:0]};
			[5'd16:5'd23]:         c = asc("0") + {4'd0, r[2:0]};
			5'd24:                 c = asc("8");
			5'd25:                 c = asc("9");
			[5'd28:5'd30]:         c = asc("p");
			default:               c = asc("a");
		endcase
		return c;
	endfunction

	// one double-dabble step: adjust digits, shift in one bit
	function automatic logic [4*BCD_DIGITS-1:0] dabble(input logic [4*BCD_DIGITS-1:0] b,
			input logic bit_in);
		logic [4*BCD_DIGITS-1:0] a;
		a = b;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (a[4*i +: 4] >= 4'd5)
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
		end
		return {a[4*BCD_DIGITS-2:0], bit_in};
	endfunction

endpackage

// File: hdl/mips_instruction_to_text_unit.sv
// ----------------------------------------------------------------------------
// mips_instruction_to_text_unit
// Renders a MIPS instruction word as ASCII assembly text, one character
// per output transaction, using a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  instr   | instr_valid, instr_ready, instr_word         | in
//  text    | text_valid, text_ready, text_char,           | out
//          | last_char, unknown_op                        |
//
//  One microcode step per cycle unless the text channel stalls or the
//  wait step holds: a step per character, a converter wait step, and an
//  empty step for each "$0" that is not last. The converter starts at
//  accept and runs on its own; the wait step holds until it is done.
//  Reset clears the sequencer and output valid. A stalled text channel holds
//  the sequencer; a new word is taken once the last character is registered.
// ----------------------------------------------------------------------------
module mips_instruction_to_text_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instr_word,
	output logic        text_valid,
	input  logic        text_ready,
	output logic [6:0]  text_char,
	output logic        last_char,
	output logic        unknown_op
);
	import mitt_pkg::*;

	logic                    busy_q;
	logic [PC_W-1:0]         pc_q;
	logic [4:0]              rs_q, rt_q, rd_q;
	logic [4*BCD_DIGITS-1:0] bcd_q;
	logic [BIN_W-1:0]        bin_q;
	logic [3:0]              cnt_q;
	logic [2:0]              dig_q;
	logic                    text_valid_q;
	logic [6:0]              text_char_q;
	logic                    last_char_q;
	logic                    unknown_op_q;

	ucode_t          cw;
	logic [4:0]      r;
	logic            emits, e_last, e_unk, step_done, go, emit_ok;
	logic [6:0]      e_char;
	logic [3:0]      digit;
	logic [2:0]      msd;
	logic [PC_W-1:0] start_pc;
	logic [5:0]      opc, fn;
	logic            accept;
	logic [4*BCD_DIGITS-1:0] bcd_mid;

	assign accept      = instr_valid && instr_ready;
	assign instr_ready = !busy_q;
	assign emit_ok     = !text_valid_q || text_ready;

	assign opc = instr_word[31:26];
	assign fn  = instr_word[5:0];

	always_comb begin
		start_pc = PC_UNK;
		unique case (opc)
			OPC_RTYPE: begin
				if (fn == FN_ADD)
					start_pc = PC_ADD;
				else if (fn == FN_SUB)
					start_pc = PC_SUB;
				else if (fn == FN_SLT)
					start_pc = PC_SLT;
			end
			OPC_LW:  start_pc = PC_LW;
			OPC_SW:  start_pc = PC_SW;
			OPC_BEQ: start_pc = PC_BEQ;
			OPC_J:   start_pc = PC_J;
			default: start_pc = PC_UNK;
		endcase
	end

	// most significant nonzero digit
	always_comb begin
		msd = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0)
				msd = 3'(i);
		end
	end

	assign digit = bcd_q[4*dig_q +: 4];
	assign cw    = ucode_rom(pc_q);

	always_comb begin
		case (cw.rsel)
			SEL_RT:  r = rt_q;
			SEL_RD:  r = rd_q;
			default: r = rs_q;
		endcase
	end

	always_comb begin
		emits     = 1'b1;
		e_char    = cw.chr;
		e_last    = cw.last;
		e_unk     = 1'b0;
		step_done = 1'b1;
		unique case (cw.op)
			OP_CHAR: ;
			OP_REGA: begin
				e_char = reg_char1(r);
				e_last = cw.last && (r == 5'd0);
			end
			OP_REGB: begin
				emits  = (r != 5'd0);
				e_char = reg_char2(r);
			end
			OP_WAIT: begin
				emits     = 1'b0;
				step_done = (cnt_q == 4'd0);
			end
			OP_DIGIT: begin
				e_char    = asc("0") + {3'd0, digit};
				e_last    = cw.last && (dig_q == 3'd0);
				step_done = (dig_q == 3'd0);
			end
			default: begin
				e_char = 7'd0;
				e_last = 1'b1;
				e_unk  = 1'b1;
			end
		endcase
		go = busy_q && (!emits || emit_ok);
	end

	assign bcd_mid = dabble(bcd_q, bin_q[BIN_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= (opc == OPC_J) ? CNT_TGT : CNT_IMM;
			end else begin
				if (cnt_q != 4'd0)
					cnt_q <= cnt_q - 4'd1;
				if (go && emits && e_last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q  <= start_pc;
			rs_q  <= instr_word[25:21];
			rt_q  <= instr_word[20:16];
			rd_q  <= instr_word[15:11];
			bcd_q <= '0;
			if (opc == OPC_J)
				bin_q <= instr_word[BIN_W-1:0];
			else
				bin_q <= {instr_word[IMM_W-1:0], (BIN_W-IMM_W)'(0)};
		end else begin
			if (cnt_q != 4'd0) begin
				bcd_q <= dabble(bcd_mid, bin_q[BIN_W-2]);
				bin_q <= {bin_q[BIN_W-3:0], 2'b00};
			end
			if (go) begin
				if (cw.op == OP_WAIT && step_done)
					dig_q <= msd;
				if (cw.op == OP_DIGIT && !step_done)
					dig_q <= dig_q - 3'd1;
				if (step_done)
					pc_q <= cw.jmp ? cw.tgt : pc_q + 6'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (go && emits) begin
			text_valid_q <= 1'b1;
		end else if (text_ready) begin
			text_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emits) begin
			text_char_q  <= e_char;
			last_char_q  <= e_last;
			unknown_op_q <= e_unk;
		end
	end

	assign text_valid = text_valid_q;
	assign text_char  = text_char_q;
	assign last_char  = last_char_q;
	assign unknown_op = unknown_op_q;

endmodule

// File: tb/tb_mips_instruction_to_text_unit.sv
// ----------------------------------------------------------------------------
// tb_mips_instruction_to_text_unit
// Feeds instruction words into the text unit and checks every output
// character, last marker and unknown flag against a local renderer of
// the assembly line. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_mips_instruction_to_text_unit;

	import mitt_pkg::*;

	typedef struct {
		logic [31:0] word;
		int unsigned gap;
	} instr_txn_t;

	typedef struct {
		logic [6:0] chr;
		logic       last;
		logic       unk;
	} text_txn_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        instr_valid = 1'b0;
	logic        instr_ready;
	logic [31:0] instr_word = '0;
	logic        text_valid;
	logic        text_ready = 1'b0;
	logic [6:0]  text_char;
	logic        last_char;
	logic        unknown_op;

	instr_txn_t  instr_queue[$];
	text_txn_t   text_expected[$];
	bit          failed = 1'b0;
	int unsigned idle_cnt = 0;
	int unsigned stall_cnt = 0;
	int unsigned stall_draw;
	int unsigned rx_count = 0;
	bit          rx_burst = 1'b0;

	string abi_reg_name [32] = '{
		"$0",  "$at", "$v0", "$v1", "$a0", "$a1", "$a2", "$a3",
		"$t0", "$t1", "$t2", "$t3", "$t4", "$t5", "$t6", "$t7",
		"$s0", "$s1", "$s2", "$s3", "$s4", "$s5", "$s6", "$s7",
		"$t8", "$t9", "$k0", "$k1", "$gp", "$sp", "$fp", "$ra"
	};

	mips_instruction_to_text_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr_word  (instr_word),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_char   (text_char),
		.last_char   (last_char),
		.unknown_op  (unknown_op)
	);

	// expected characters of the assembly line for one word
	function automatic void render_instr(input logic [31:0] w);
		logic [5:0]  opc;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [25:0] tgt;
		string       s;
		text_txn_t   t;
		opc = w[31:26];
		fn  = w[5:0];
		rs  = w[25:21];
		rt  = w[20:16];
		rd  = w[15:11];
		imm = w[15:0];
		tgt = w[25:0];
		if (opc == OPC_RTYPE && (fn == FN_ADD || fn == FN_SUB || fn == FN_SLT)) begin
			s = (fn == FN_ADD) ? "add " : ((fn == FN_SUB) ? "sub " : "slt ");
			s = {s, abi_reg_name[rd], ",", abi_reg_name[rs], ",", abi_reg_name[rt]};
		end else if (opc == OPC_LW || opc == OPC_SW) begin
			s = (opc == OPC_LW) ? "lw " : "sw ";
			s = {s, abi_reg_name[rt], ",", $sformatf("%0d", imm), "(",
				abi_reg_name[rs], ")"};
		end else if (opc == OPC_BEQ) begin
			s = {"beq ", abi_reg_name[rs], ",", abi_reg_name[rt], ",",
				$sformatf("%0d", imm)};
		end else if (opc == OPC_J) begin
			s = {"j ", $sformatf("%0d", tgt)};
		end else begin
			t.chr = 7'd0;
			t.last = 1'b1;
			t.unk = 1'b1;
			text_expected.push_back(t);
			return;
		end
		for (int i = 0; i < s.len(); i++) begin
			t.chr = 7'(s[i]);
			t.last = (i == s.len() - 1);
			t.unk = 1'b0;
			text_expected.push_back(t);
		end
	endfunction

	function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] sh);
		return {OPC_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	// numbers spread over zero, short, full-width and maximum
	function automatic logic [25:0] pick_number(input int unsigned width);
		logic [25:0] mask;
		mask = (26'd1 << width) - 26'd1;
		case ($urandom_range(0, 5))
			0: return 26'd0;
			1: return 26'($urandom_range(1, 9));
			2: return 26'($urandom_range(10, 9999));
			3: return mask;
			default: return 26'($urandom()) & mask;
		endcase
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		logic [5:0]  fn;
		w = $urandom();
		case ($urandom_range(0, 9))
			0: return enc_r(FN_ADD, w[15:11], w[25:21], w[20:16], w[10:6]);
			1: return enc_r(FN_SUB, w[15:11], w[25:21], w[20:16], w[10:6]);
			2: return enc_r(FN_SLT, w[15:11], w[25:21], w[20:16], w[10:6]);
			3: return enc_i(OPC_LW, w[25:21], w[20:16], 16'(pick_number(16)));
			4: return enc_i(OPC_SW, w[25:21], w[20:16], 16'(pick_number(16)));
			5: return enc_i(OPC_BEQ, w[25:21], w[20:16], 16'(pick_number(16)));
			6: return {OPC_J, pick_number(26)};
			7: begin
				fn = 6'($urandom());
				return {OPC_RTYPE, w[25:6], fn};
			end
			default: return w;
		endcase
	endfunction

	function automatic void queue_instr(input logic [31:0] w, input bit burst);
		instr_txn_t it;
		it.word = w;
		it.gap = burst ? 0 : $urandom_range(0, 7);
		instr_queue.push_back(it);
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_valid <= 1'b0;
			idle_cnt <= 0;
		end else begin
			if (instr_valid && instr_ready)
				render_instr(instr_word);
			if (!instr_valid || instr_ready) begin
				if (instr_queue.size() == 0) begin
					instr_valid <= 1'b0;
				end else if (idle_cnt < instr_queue[0].gap) begin
					idle_cnt <= idle_cnt + 1;
					instr_valid <= 1'b0;
				end else begin
					instr_word <= instr_queue[0].word;
					instr_valid <= 1'b1;
					idle_cnt <= 0;
					void'(instr_queue.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (text_valid && text_ready) begin
				if (text_expected.size() == 0) begin
					$display("%0t unexpected text transaction: char %h last %b unk %b",
						$time, text_char, last_char, unknown_op);
					failed = 1'b1;
				end else begin
					if (text_char !== text_expected[0].chr
							|| last_char !== text_expected[0].last
							|| unknown_op !== text_expected[0].unk) begin
						$display("%0t mismatch: expected char %h last %b unk %b, got char %h last %b unk %b",
							$time, text_expected[0].chr, text_expected[0].last,
							text_expected[0].unk, text_char, last_char, unknown_op);
						failed = 1'b1;
					end
					void'(text_expected.pop_front());
				end
				rx_count++;
				if (rx_count % 64 == 0)
					rx_burst = ($urandom_range(0, 2) == 0);
				stall_draw = rx_burst ? 0 : $urandom_range(0, 7);
				stall_cnt <= stall_draw;
				text_ready <= (stall_draw == 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				text_ready <= (stall_cnt == 1);
			end else begin
				text_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned guard;
		bit          burst;
		queue_instr(32'h0000_0000, 1'b0);
		queue_instr(32'hFFFF_FFFF, 1'b0);
		queue_instr(enc_r(FN_ADD, 5'd0, 5'd0, 5'd0, 5'd0), 1'b0);
		queue_instr(enc_r(FN_ADD, 5'd31, 5'd1, 5'd2, 5'd31), 1'b0);
		queue_instr(enc_r(FN_SUB, 5'd8, 5'd16, 5'd0, 5'd5), 1'b0);
		queue_instr(enc_r(FN_SLT, 5'd31, 5'd31, 5'd31, 5'd31), 1'b0);
		queue_instr(enc_r(6'd33, 5'd3, 5'd4, 5'd5, 5'd0), 1'b0);
		queue_instr(enc_i(OPC_LW, 5'd0, 5'd0, 16'd0), 1'b0);
		queue_instr(enc_i(OPC_LW, 5'd31, 5'd31, 16'hFFFF), 1'b0);
		queue_instr(enc_i(OPC_SW, 5'd30, 5'd29, 16'd4), 1'b0);
		queue_instr(enc_i(OPC_SW, 5'd0, 5'd24, 16'd10), 1'b0);
		queue_instr(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'd0), 1'b0);
		queue_instr(enc_i(OPC_BEQ, 5'd31, 5'd31, 16'hFFFF), 1'b0);
		queue_instr(enc_i(OPC_BEQ, 5'd26, 5'd28, 16'd100), 1'b0);
		queue_instr({OPC_J, 26'd0}, 1'b0);
		queue_instr({OPC_J, 26'h3FF_FFFF}, 1'b0);
		queue_instr({OPC_J, 26'd1234567}, 1'b0);
		queue_instr(enc_i(6'd5, 5'd1, 5'd2, 16'd3), 1'b0);
		queue_instr({OPC_J, 26'd0}, 1'b1);
		queue_instr(enc_i(OPC_LW, 5'd7, 5'd9, 16'd0), 1'b1);
		burst = 1'b0;
		for (int n = 0; n < 330; n++) begin
			if (n % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			queue_instr(random_word(), burst);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (instr_queue.size() != 0 || instr_valid)
			@(posedge clk);
		guard = 0;
		while (text_expected.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		if (text_expected.size() != 0) begin
			$display("%0t %0d expected text transactions never arrived, next char %h",
				$time, text_expected.size(), text_expected[0].chr);
			failed = 1'b1;
		end
		if (!failed)
			$display("[mips_instruction_to_text_unit] OK");
		else
			$display("[mips_instruction_to_text_unit] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[mips_instruction_to_text_unit] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
hdl/mitt_pkg.sv
hdl/mips_instruction_to_text_unit.sv
tb/tb_mips_instruction_to_text_unit.sv
